@@ sv/aps_pkg.sv @@
// Shared types and constants for the axis positioning sequencer.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package aps_pkg;

  localparam int unsigned ANGLE_W = 31;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 32;

  localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST    = 31'd0;
  localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST    = 31'd1295999999;
  localparam logic [19:0]        HOLD_ERROR_RST   = 20'd14318;
  localparam logic [26:0]        SETTLE_ERROR_RST = 27'd18048170;
  localparam logic [23:0]        IDLE_ERROR_RST   = 24'd71593;
  localparam logic [26:0]        SPEED_LIMIT_RST  = 27'd103132;
  localparam logic [TICK_W-1:0]  TIMEOUT_RST      = 16'd10000;

  typedef enum logic [2:0] {
    OP_UPDATE = 3'd0,
    OP_SET    = 3'd1,
    OP_RELEASE = 3'd2,
    OP_TEST   = 3'd3,
    OP_MANUAL = 3'd4
  } opcode_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_MIN_ANGLE    = 3'd0,
    REG_MAX_ANGLE    = 3'd1,
    REG_HOLD_ERROR   = 3'd2,
    REG_SETTLE_ERROR = 3'd3,
    REG_IDLE_ERROR   = 3'd4,
    REG_SPEED_LIMIT  = 3'd5,
    REG_TIMEOUT      = 3'd6
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_WAIT      = 4'd0,
    ST_INIT      = 4'd1,
    ST_IDLE      = 4'd2,
    ST_UNBLOCK   = 4'd3,
    ST_ROTATE    = 4'd4,
    ST_BLOCKING  = 4'd5,
    ST_STOPMOTOR = 4'd6,
    ST_VERIFY    = 4'd7,
    ST_STOPHERE  = 4'd8,
    ST_TEST      = 4'd9,
    ST_MANUAL    = 4'd10
  } mover_state_t;

  localparam logic [1:0] BRK_NONE = 2'd0;
  localparam logic [1:0] BRK_ON   = 2'd1;
  localparam logic [1:0] BRK_OFF  = 2'd2;

  localparam logic [1:0] BSTAT_INACTIVE = 2'd0;
  localparam logic [1:0] BSTAT_ACTIVE   = 2'd1;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [31:0]        target_angle;
    logic               hold_brake;
    logic               encoder_reliable;
    logic               axis_known;
    logic               drive_ready;
    logic               motor_enabled;
    logic [1:0]         brake_status;
    logic signed [31:0] current_angle;
    logic signed [31:0] shaft_speed;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         mover_state;
    logic [1:0]         brake_command;
    logic               motor_disable;
    logic               move_valid;
    logic [ANGLE_W-1:0] move_target;
    logic               braked_idle;
    logic               init_done;
  } res_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] min_angle;
    logic [ANGLE_W-1:0] max_angle;
    logic [19:0]        hold_error;
    logic [26:0]        settle_error;
    logic [23:0]        idle_error;
    logic [26:0]        speed_limit;
    logic [TICK_W-1:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    mover_state_t       ctrl_state;
    logic               initialized;
    logic [ANGLE_W-1:0] requested_angle;
    logic [ANGLE_W-1:0] active_angle;
    logic               requested_hold;
    logic               active_hold;
    logic               timer_running;
    logic [TICK_W-1:0]  timer_count;
  } seq_state_t;

endpackage

@@ sv/aps_cfg_regs.sv @@
// Configuration register bank of the axis positioning sequencer.
// Depends on aps_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module aps_cfg_regs
  import aps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  output cfg_t               cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_angle     <= MIN_ANGLE_RST;
      cfg.max_angle     <= MAX_ANGLE_RST;
      cfg.hold_error    <= HOLD_ERROR_RST;
      cfg.settle_error  <= SETTLE_ERROR_RST;
      cfg.idle_error    <= IDLE_ERROR_RST;
      cfg.speed_limit   <= SPEED_LIMIT_RST;
      cfg.timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      // indexes past the list are dropped
      case (cfg_index)
        REG_MIN_ANGLE:    cfg.min_angle     <= cfg_data[ANGLE_W-1:0];
        REG_MAX_ANGLE:    cfg.max_angle     <= cfg_data[ANGLE_W-1:0];
        REG_HOLD_ERROR:   cfg.hold_error    <= cfg_data[19:0];
        REG_SETTLE_ERROR: cfg.settle_error  <= cfg_data[26:0];
        REG_IDLE_ERROR:   cfg.idle_error    <= cfg_data[23:0];
        REG_SPEED_LIMIT:  cfg.speed_limit   <= cfg_data[26:0];
        REG_TIMEOUT:      cfg.timeout_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/aps_step.sv @@
// Next-state and result logic for one command of the positioning sequencer.
// Depends on aps_pkg for cmd_t, res_t, cfg_t, seq_state_t and codes.
`timescale 1ns / 1ps

module aps_step
  import aps_pkg::*;
(
  input  cmd_t       cmd,
  input  cfg_t       cfg,
  input  seq_state_t st,
  output seq_state_t st_next,
  output res_t       res_next
);

  // Clamp 34-bit signed v to [min_angle, max_angle]; crossed: max unless v<min.
  function automatic logic [ANGLE_W-1:0] clamp_angle(input logic signed [33:0] v,
                                                     input cfg_t c);
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    lo = $signed({3'b000, c.min_angle});
    hi = $signed({3'b000, c.max_angle});
    if (v < lo) clamp_angle = c.min_angle;
    else if (v > hi) clamp_angle = c.max_angle;
    else clamp_angle = v[ANGLE_W-1:0];
  endfunction

  logic signed [33:0] diff;
  logic [32:0]        err;
  logic [32:0]        spd;
  logic               moving;
  logic [1:0]         brk;
  logic               dis;
  logic               mv;
  logic               brake_active;
  logic               brake_inactive;

  always_comb begin
    diff = $signed({{2{cmd.current_angle[31]}}, cmd.current_angle})
         - $signed({3'b000, st.active_angle});
    err  = diff[33] ? 33'(-diff) : diff[32:0];
    spd  = cmd.shaft_speed[31] ? (33'd0 - {cmd.shaft_speed[31], cmd.shaft_speed})
                               : {1'b0, cmd.shaft_speed};
    moving = spd > {6'd0, cfg.speed_limit};
    brake_active   = (cmd.brake_status == BSTAT_ACTIVE);
    brake_inactive = (cmd.brake_status == BSTAT_INACTIVE);
  end

  always_comb begin
    st_next = st;
    brk     = BRK_NONE;
    dis     = 1'b0;
    mv      = 1'b0;

    case (cmd.opcode)
      OP_SET: begin
        st_next.requested_angle = clamp_angle($signed({2'b00, cmd.target_angle}), cfg);
        st_next.requested_hold  = cmd.hold_brake;
      end
      OP_RELEASE: begin
        if (st.initialized) begin
          st_next.ctrl_state = ST_STOPHERE;
        end else begin
          brk = BRK_OFF;
          st_next.ctrl_state = ST_INIT;
        end
      end
      OP_TEST: st_next.ctrl_state = ST_TEST;
      OP_MANUAL: begin
        brk = BRK_OFF;
        st_next.ctrl_state = ST_MANUAL;
      end
      OP_UPDATE: begin
        // timer advances before the state step and saturates
        if (st.timer_running && (st.timer_count != {TICK_W{1'b1}}))
          st_next.timer_count = st.timer_count + 1'b1;
        if (cmd.encoder_reliable && cmd.axis_known) st_next.initialized = 1'b1;

        case (st.ctrl_state)
          ST_WAIT: begin
            if (cmd.encoder_reliable) st_next.ctrl_state = ST_INIT;
          end
          ST_INIT: begin
            if (cmd.drive_ready) begin
              dis = cmd.motor_enabled;
              brk = st.requested_hold ? BRK_ON : BRK_OFF;
              st_next.ctrl_state = ST_IDLE;
            end
          end
          ST_IDLE: begin
            if ((st.active_angle != st.requested_angle) ||
                (st.active_hold != st.requested_hold)) begin
              st_next.ctrl_state   = ST_UNBLOCK;
              st_next.active_angle = st.requested_angle;
              st_next.active_hold  = st.requested_hold;
            end
          end
          ST_UNBLOCK: begin
            if (!brake_inactive) begin
              brk = BRK_OFF;
            end else begin
              mv = 1'b1;
              st_next.ctrl_state = ST_ROTATE;
            end
          end
          ST_VERIFY: begin
            st_next.ctrl_state = (err < {9'd0, cfg.idle_error}) ? ST_IDLE : ST_UNBLOCK;
          end
          ST_STOPMOTOR: begin
            if (moving) dis = cmd.motor_enabled;
            else st_next.ctrl_state = ST_VERIFY;
          end
          ST_ROTATE: begin
            if ((err <= {13'd0, cfg.hold_error}) && !moving) begin
              st_next.ctrl_state    = ST_BLOCKING;
              st_next.timer_running = 1'b0;
            end else begin
              if (err < {6'd0, cfg.settle_error}) begin
                if (st.timer_running) begin
                  if (st_next.timer_count >= cfg.timeout_ticks) begin
                    st_next.timer_running = 1'b0;
                    st_next.ctrl_state = (err >= {9'd0, cfg.idle_error}) ? ST_STOPHERE
                                                                         : ST_BLOCKING;
                  end
                end else begin
                  st_next.timer_running = 1'b1;
                  st_next.timer_count   = '0;
                end
              end
              // a new target restarts the move
              if (st.active_angle != st.requested_angle) begin
                st_next.ctrl_state    = ST_ROTATE;
                st_next.active_angle  = st.requested_angle;
                st_next.timer_running = 1'b0;
                mv = 1'b1;
              end
            end
          end
          ST_BLOCKING: begin
            if (st.active_hold && !brake_active) brk = BRK_ON;
            else st_next.ctrl_state = ST_STOPMOTOR;
          end
          ST_STOPHERE: begin
            dis = cmd.motor_enabled;
            if (!moving) begin
              if (st.requested_hold && !brake_active) begin
                brk = BRK_ON;
              end else begin
                st_next.requested_angle = clamp_angle(
                    $signed({{2{cmd.current_angle[31]}}, cmd.current_angle}), cfg);
                st_next.active_angle = st_next.requested_angle;
                brk = st.requested_hold ? BRK_ON : BRK_OFF;
                st_next.ctrl_state = ST_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    res_next.mover_state   = st_next.ctrl_state;
    res_next.brake_command = brk;
    res_next.motor_disable = dis;
    res_next.move_valid    = mv;
    res_next.move_target   = mv ? st_next.active_angle : '0;
    res_next.braked_idle   = brake_active && (st_next.ctrl_state == ST_IDLE);
    res_next.init_done     = st_next.initialized;
  end

endmodule

@@ sv/axis_positioning_sequencer.sv @@
// Top level of the axis positioning sequencer: command register, state,
// result register. Depends on aps_pkg, aps_cfg_regs and aps_step.
`timescale 1ns / 1ps

// Usage
// - cmd channel (cmd_valid/cmd_ready/cmd): one beat is one command, either an
//   update tick with sensor samples or a set-target, release, test or manual
//   rotate request.
// - res channel (res_valid/res_ready/res): exactly one beat per command, in
//   command order, carrying the state number and brake and motor requests.
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always taken; write only while no command is in flight.
// Path: an accepted command waits in the command register and is stepped into
// the result register once that is free or draining; its beat is offered there.
// Throughput: one command per cycle while res_ready is high; the step is one
// pass of compares, subtractions and an increment between the two registers.
// Reset: state returns to waiting for encoder data, targets and timer clear,
// configuration takes its default values, both pipeline registers empty.
// Stall: when res_ready is low the result holds; one more command can still
// be taken into the command register, after which cmd_ready drops.
module axis_positioning_sequencer
  import aps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  cmd_t       cmd_q;
  logic       cmd_q_valid;
  seq_state_t st;
  seq_state_t st_next;
  res_t       res_next;
  logic       advance;

  aps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  aps_step u_step (
    .cmd      (cmd_q),
    .cfg      (cfg),
    .st       (st),
    .st_next  (st_next),
    .res_next (res_next)
  );

  // Step the held command when the result register is free or draining.
  assign advance   = cmd_q_valid && (!res_valid || res_ready);
  assign cmd_ready = !cmd_q_valid || advance;

  // Command register: capture a new beat whenever the slot frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else if (cmd_ready) begin
      cmd_q_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) cmd_q <= cmd;
  end

  // Sequencer state advances once per stepped command.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.ctrl_state      <= ST_WAIT;
      st.initialized     <= 1'b0;
      st.requested_angle <= '0;
      st.active_angle    <= '0;
      st.requested_hold  <= 1'b0;
      st.active_hold     <= 1'b0;
      st.timer_running   <= 1'b0;
      st.timer_count     <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register: load on a step, drop valid once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res <= res_next;
  end

endmodule

@@ dv/axis_positioning_sequencer_tb.sv @@
// Self-checking testbench for the axis positioning sequencer.
// Depends on aps_pkg and axis_positioning_sequencer; drives command and config beats,
// predicts or looks up every result beat in-bench and compares field by field.
`timescale 1ns / 1ps

module axis_positioning_sequencer_tb;
  import aps_pkg::*;

  // Opcodes the block must ignore, and brake states the package leaves unnamed.
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
  localparam logic [1:0] BSTAT_MOVING    = 2'd2;
  localparam logic [1:0] BSTAT_UNKNOWN   = 2'd3;

  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned N_SETTINGS      = 6;
  localparam int unsigned ITEMS_PER_PHASE = 225;
  localparam int unsigned IDLE_PCT        = 72;
  localparam int unsigned BOTH_IDLE_PCT   = 15;
  localparam int unsigned HOLD_OFF_CYCLES = 64;
  localparam int unsigned DRAIN_CYCLES    = 8;    // two-stage pipe plus margin
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  logic               clk;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_ready;
  cmd_t               cmd;
  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CDATA_W-1:0] cfg_data;

  axis_positioning_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the sequencer state and of its limit registers.
  seq_state_t axis_model;
  cfg_t       limits;

  // Result beats still owed by the block, oldest first.
  res_t       step_results_q[$];

  typedef struct {
    cmd_t c;
    bit   typed;
    res_t want;
  } dir_row_t;

  dir_row_t    directed_q[$];
  cfg_t        cfg_plan[N_SETTINGS];

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  bit          hold_off_req;
  int unsigned mismatch_count;
  int unsigned cmds_sent;
  int unsigned results_seen;
  int unsigned moves_seen;
  int unsigned disables_seen;
  logic [15:0] states_seen;
  int unsigned quiet_cycles;
  res_t        want_res;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [ANGLE_W-1:0] clamp_angle(longint v);
    if (v < longint'(limits.min_angle)) return limits.min_angle;
    if (v > longint'(limits.max_angle)) return limits.max_angle;
    return v[ANGLE_W-1:0];
  endfunction

  // Advance the shadow sequencer by one command beat and return its result.
  function automatic res_t step_axis(cmd_t c);
    res_t       r;
    logic [1:0] brk;
    bit         dis;
    bit         mv;
    bit         moving;
    longint     cur;
    longint     spd;
    longint     err;
    brk = BRK_NONE;
    dis = 1'b0;
    mv  = 1'b0;
    cur = longint'($signed(c.current_angle));
    spd = longint'($signed(c.shaft_speed));
    if (spd < 0) spd = -spd;
    moving = spd > longint'(limits.speed_limit);

    case (c.opcode)
      OP_SET: begin
        axis_model.requested_angle = clamp_angle(longint'(c.target_angle));
        axis_model.requested_hold  = c.hold_brake;
      end
      OP_RELEASE: begin
        if (axis_model.initialized) begin
          axis_model.ctrl_state = ST_STOPHERE;
        end else begin
          brk = BRK_OFF;
          axis_model.ctrl_state = ST_INIT;
        end
      end
      OP_TEST: axis_model.ctrl_state = ST_TEST;
      OP_MANUAL: begin
        brk = BRK_OFF;
        axis_model.ctrl_state = ST_MANUAL;
      end
      OP_UPDATE: begin
        // Error is taken against the target held before this tick.
        err = cur - longint'(axis_model.active_angle);
        if (err < 0) err = -err;
        if (axis_model.timer_running && axis_model.timer_count != '1)
          axis_model.timer_count++;
        if (c.encoder_reliable && c.axis_known) axis_model.initialized = 1'b1;

        case (axis_model.ctrl_state)
          ST_WAIT: if (c.encoder_reliable) axis_model.ctrl_state = ST_INIT;
          ST_INIT: begin
            if (c.drive_ready) begin
              if (c.motor_enabled) dis = 1'b1;
              brk = axis_model.requested_hold ? BRK_ON : BRK_OFF;
              axis_model.ctrl_state = ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (axis_model.active_angle != axis_model.requested_angle ||
                axis_model.active_hold != axis_model.requested_hold) begin
              axis_model.ctrl_state   = ST_UNBLOCK;
              axis_model.active_angle = axis_model.requested_angle;
              axis_model.active_hold  = axis_model.requested_hold;
            end
          end
          ST_UNBLOCK: begin
            if (c.brake_status != BSTAT_INACTIVE) begin
              brk = BRK_OFF;
            end else begin
              mv = 1'b1;
              axis_model.ctrl_state = ST_ROTATE;
            end
          end
          ST_VERIFY: begin
            axis_model.ctrl_state = (err < longint'(limits.idle_error)) ? ST_IDLE : ST_UNBLOCK;
          end
          ST_STOPMOTOR: begin
            if (moving) begin
              if (c.motor_enabled) dis = 1'b1;
            end else begin
              axis_model.ctrl_state = ST_VERIFY;
            end
          end
          ST_ROTATE: begin
            if (err <= longint'(limits.hold_error) && !moving) begin
              axis_model.ctrl_state    = ST_BLOCKING;
              axis_model.timer_running = 1'b0;
            end else begin
              if (err < longint'(limits.settle_error)) begin
                if (axis_model.timer_running) begin
                  if (axis_model.timer_count >= limits.timeout_ticks) begin
                    axis_model.timer_running = 1'b0;
                    axis_model.ctrl_state = (err >= longint'(limits.idle_error)) ?
                                            ST_STOPHERE : ST_BLOCKING;
                  end
                end else begin
                  axis_model.timer_running = 1'b1;
                  axis_model.timer_count   = '0;
                end
              end
              // A new target restarts the move regardless of the timer.
              if (axis_model.active_angle != axis_model.requested_angle) begin
                axis_model.ctrl_state    = ST_ROTATE;
                axis_model.active_angle  = axis_model.requested_angle;
                axis_model.timer_running = 1'b0;
                mv = 1'b1;
              end
            end
          end
          ST_BLOCKING: begin
            if (axis_model.active_hold && c.brake_status != BSTAT_ACTIVE) brk = BRK_ON;
            else axis_model.ctrl_state = ST_STOPMOTOR;
          end
          ST_STOPHERE: begin
            if (c.motor_enabled) dis = 1'b1;
            if (!moving) begin
              if (axis_model.requested_hold && c.brake_status != BSTAT_ACTIVE) begin
                brk = BRK_ON;
              end else begin
                axis_model.requested_angle = clamp_angle(cur);
                axis_model.active_angle    = axis_model.requested_angle;
                brk = axis_model.requested_hold ? BRK_ON : BRK_OFF;
                axis_model.ctrl_state = ST_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    r.mover_state   = axis_model.ctrl_state;
    r.brake_command = brk;
    r.motor_disable = dis;
    r.move_valid    = mv;
    r.move_target   = mv ? axis_model.active_angle : '0;
    r.braked_idle   = (c.brake_status == BSTAT_ACTIVE) && (axis_model.ctrl_state == ST_IDLE);
    r.init_done     = axis_model.initialized;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic cmd_t mk_cmd(logic [2:0] op, logic [31:0] tgt, logic hold,
                                  logic rel, logic known, logic rdy, logic en,
                                  logic [1:0] bs, logic signed [31:0] cur,
                                  logic signed [31:0] spd);
    cmd_t c;
    c.opcode           = op;
    c.target_angle     = tgt;
    c.hold_brake       = hold;
    c.encoder_reliable = rel;
    c.axis_known       = known;
    c.drive_ready      = rdy;
    c.motor_enabled    = en;
    c.brake_status     = bs;
    c.current_angle    = cur;
    c.shaft_speed      = spd;
    return c;
  endfunction

  function automatic res_t mk_res(mover_state_t st, logic [1:0] brk, logic dis,
                                  logic mv, logic [ANGLE_W-1:0] tgt, logic bidle,
                                  logic init);
    res_t r;
    r.mover_state   = st;
    r.brake_command = brk;
    r.motor_disable = dis;
    r.move_valid    = mv;
    r.move_target   = tgt;
    r.braked_idle   = bidle;
    r.init_done     = init;
    return r;
  endfunction

  task automatic add_row(bit typed, cmd_t c, res_t want);
    dir_row_t row;
    row.c     = c;
    row.typed = typed;
    row.want  = want;
    directed_q.push_back(row);
  endtask

  // Mostly well-formed traffic: update ticks whose angle sits near the active
  // target and whose speed straddles the stop threshold, with occasional target
  // changes, parking commands, releases and ignored opcodes mixed in.
  function automatic cmd_t random_cmd();
    cmd_t         c;
    logic [127:0] raw;
    int unsigned  pick;
    longint       span;
    longint       off;
    longint       mag;
    raw  = {$urandom(), $urandom(), $urandom(), $urandom()};
    c    = raw[$bits(cmd_t)-1:0];
    pick = $urandom_range(199);
    if (pick < 160)      c.opcode = OP_UPDATE;
    else if (pick < 180) c.opcode = OP_SET;
    else if (pick < 188) c.opcode = OP_RELEASE;
    else if (pick < 191) c.opcode = OP_TEST;
    else if (pick < 194) c.opcode = OP_MANUAL;
    else                 c.opcode = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));

    c.encoder_reliable = ($urandom_range(9) != 0);
    c.axis_known       = ($urandom_range(9) != 0);
    c.drive_ready      = ($urandom_range(6) != 0);
    pick = $urandom_range(19);
    if (pick < 9)        c.brake_status = BSTAT_INACTIVE;
    else if (pick < 18)  c.brake_status = BSTAT_ACTIVE;
    else if (pick == 18) c.brake_status = BSTAT_MOVING;
    else                 c.brake_status = BSTAT_UNKNOWN;

    pick = $urandom_range(9);
    if (pick <= 6) begin
      case ($urandom_range(3))
        0:       span = longint'(limits.hold_error) + 1;
        1:       span = longint'(limits.idle_error) + 1;
        2:       span = longint'(limits.settle_error) + 1;
        default: span = 4 * longint'(limits.settle_error) + 1;
      endcase
      if (pick == 6) span = longint'(limits.hold_error) + 1;
      off = longint'($urandom_range(0, 32'(2 * span))) - span;
      if (pick == 6) c.current_angle = 32'(longint'(axis_model.requested_angle) + off);
      else           c.current_angle = 32'(longint'(axis_model.active_angle) + off);
    end else if (pick == 7) begin
      c.current_angle = 32'(-longint'($urandom_range(1, 1000000)));
    end

    pick = $urandom_range(9);
    if (pick <= 7) begin
      if (pick <= 4) mag = longint'($urandom_range(0, limits.speed_limit));
      else           mag = longint'(limits.speed_limit) + longint'($urandom_range(1, 50000));
      c.shaft_speed = $urandom_range(1) ? 32'(-mag) : 32'(mag);
    end

    if (c.opcode == OP_SET) begin
      case ($urandom_range(9))
        0, 1, 2, 3: c.target_angle = $urandom_range(0, 1295999999);
        4, 5:       c.target_angle = $urandom_range(limits.min_angle, limits.max_angle);
        6:          c.target_angle = '0;
        7:          c.target_angle = '1;
        default:    ;
      endcase
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers: change inputs on the falling edge, sample on the rising one
  // ---------------------------------------------------------------------------

  // Offer one command beat, hold it until taken, then book its expected result.
  task automatic issue_cmd(cmd_t c, bit typed, res_t want);
    res_t predicted;
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
    predicted = step_axis(c);
    step_results_q.push_back(typed ? want : predicted);
    cmds_sent++;
  endtask

  // Drop the command valid and wait until every owed result has drained.
  task automatic quiesce();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (step_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CDATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_ANGLE:    limits.min_angle     = val[ANGLE_W-1:0];
      REG_MAX_ANGLE:    limits.max_angle     = val[ANGLE_W-1:0];
      REG_HOLD_ERROR:   limits.hold_error    = val[19:0];
      REG_SETTLE_ERROR: limits.settle_error  = val[26:0];
      REG_IDLE_ERROR:   limits.idle_error    = val[23:0];
      REG_SPEED_LIMIT:  limits.speed_limit   = val[26:0];
      REG_TIMEOUT:      limits.timeout_ticks = val[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_limits(cfg_t s);
    write_reg(REG_MIN_ANGLE,    s.min_angle);
    write_reg(REG_MAX_ANGLE,    s.max_angle);
    write_reg(REG_HOLD_ERROR,   s.hold_error);
    write_reg(REG_SETTLE_ERROR, s.settle_error);
    write_reg(REG_IDLE_ERROR,   s.idle_error);
    write_reg(REG_SPEED_LIMIT,  s.speed_limit);
    write_reg(REG_TIMEOUT,      s.timeout_ticks);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stall at the rate of the current phase, or hold off completely for a
  // counted stretch when asked so that the pipe fills and the command side backs up.
  initial begin
    int unsigned held;
    held      = 0;
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        held = HOLD_OFF_CYCLES;
      end
      if (held != 0) begin
        held--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each result beat with the oldest owed result.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      states_seen[res.mover_state] = 1'b1;
      if (res.move_valid) moves_seen++;
      if (res.motor_disable) disables_seen++;
      if (step_results_q.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result beat with nothing owed, expected none, actual %h",
                 $time, res);
      end else begin
        want_res = step_results_q.pop_front();
        check_field("mover_state",   want_res.mover_state,   res.mover_state);
        check_field("brake_command", want_res.brake_command, res.brake_command);
        check_field("motor_disable", want_res.motor_disable, res.motor_disable);
        check_field("move_valid",    want_res.move_valid,    res.move_valid);
        check_field("move_target",   want_res.move_target,   res.move_target);
        check_field("braked_idle",   want_res.braked_idle,   res.braked_idle);
        check_field("init_done",     want_res.init_done,     res.init_done);
      end
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles, %0d results still owed",
               $time, quiet_cycles, step_results_q.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned p;
    int unsigned n;
    rst            = 1'b1;
    cmd_valid      = 1'b0;
    cmd            = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_MIN_ANGLE;
    cfg_data       = '0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    hold_off_req   = 1'b0;
    mismatch_count = 0;
    cmds_sent      = 0;
    results_seen   = 0;
    moves_seen     = 0;
    disables_seen  = 0;
    states_seen    = '0;
    quiet_cycles   = 0;

    limits = '{MIN_ANGLE_RST, MAX_ANGLE_RST, HOLD_ERROR_RST, SETTLE_ERROR_RST,
               IDLE_ERROR_RST, SPEED_LIMIT_RST, TIMEOUT_RST};
    axis_model = '0;
    axis_model.ctrl_state = ST_WAIT;

    // Limit settings walked by the random phases: defaults with a short timer,
    // everything at its floor, everything at its ceiling, crossed limits, a
    // narrow window and tight tolerances.
    cfg_plan[0] = '{31'd0, 31'd1295999999, 20'd14318, 27'd18048170, 24'd71593,
                    27'd103132, 16'd5};
    cfg_plan[1] = '{31'd0, 31'd0, 20'd0, 27'd0, 24'd0, 27'd0, 16'd1};
    cfg_plan[2] = '{31'd1295999999, 31'd1295999999, 20'd1000000, 27'd100000000,
                    24'd10000000, 27'd100000000, 16'd65535};
    cfg_plan[3] = '{31'd900000000, 31'd100000, 20'd50000, 27'd2000000, 24'd100000,
                    27'd5000, 16'd3};
    cfg_plan[4] = '{31'd1000000, 31'd2000000, 20'd20000, 27'd500000, 24'd30000,
                    27'd2000, 16'd10};
    cfg_plan[5] = '{31'd0, 31'd1295999999, 20'd300, 27'd40000, 24'd1000, 27'd50, 16'd2};

    // Directed walk from reset with default limits. Typed rows carry results
    // obvious from the spec; the rest go through the predictor.
    // Tick without encoder data: stay waiting.
    add_row(1, mk_cmd(OP_UPDATE, 0, 0, 0, 0, 0, 0, BSTAT_INACTIVE, 0, 0),
            mk_res(ST_WAIT, BRK_NONE, 0, 0, 0, 0, 0));
    // Ignored opcode with every other field but brake status at its top.
    add_row(1, mk_cmd(OP_LAST_UNUSED, '1, 1, 1, 1, 1, 1, BSTAT_ACTIVE,
                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF),
            mk_res(ST_WAIT, BRK_NONE, 0, 0, 0, 0, 0));
    // Release before initialization starts it and frees the brake.
    add_row(1, mk_cmd(OP_RELEASE, 0, 0, 0, 0, 0, 0, BSTAT_INACTIVE, 0, 0),
            mk_res(ST_INIT, BRK_OFF, 0, 0, 0, 0, 0));
    add_row(1, mk_cmd(OP_TEST, 0, 0, 0, 0, 0, 0, BSTAT_INACTIVE, 0, 0),
            mk_res(ST_TEST, BRK_NONE, 0, 0, 0, 0, 0));
    add_row(1, mk_cmd(OP_RELEASE, 0, 0, 0, 0, 0, 0, BSTAT_INACTIVE, 0, 0),
            mk_res(ST_INIT, BRK_OFF, 0, 0, 0, 0, 0));
    // Motor not ready, axis unknown: hold in initialization.
    add_row(0, mk_cmd(OP_UPDATE, 0, 0, 1, 0, 0, 0, BSTAT_INACTIVE, 0, 0), '0);
    // Out-of-range target clamps to the upper limit.
    add_row(0, mk_cmd(OP_SET, '1, 0, 0, 0, 0, 0, BSTAT_INACTIVE, 0, 0), '0);
    add_row(1, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 1, BSTAT_INACTIVE, 0, 0),
            mk_res(ST_IDLE, BRK_OFF, 1, 0, 0, 0, 1));
    add_row(0, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 0, BSTAT_ACTIVE, 0, 0), '0);
    add_row(0, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 0, BSTAT_MOVING, 0, 0), '0);
    add_row(1, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 0, BSTAT_INACTIVE, 0, 0),
            mk_res(ST_ROTATE, BRK_NONE, 0, 1, 31'd1295999999, 0, 1));
    add_row(0, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 1, BSTAT_INACTIVE, 0, 32'sh7FFF_FFFF), '0);
    // Retarget in flight with brake hold requested.
    add_row(0, mk_cmd(OP_SET, 1000, 1, 0, 0, 0, 0, BSTAT_INACTIVE, 0, 0), '0);
    add_row(0, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 1, BSTAT_INACTIVE, 5000, 0), '0);
    // Error and speed exactly at their thresholds: ends in blocking.
    add_row(0, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 1, BSTAT_INACTIVE, 15318, 103132), '0);
    // Unknown brake status.
    add_row(0, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 1, BSTAT_UNKNOWN, 1000, 0), '0);
    // Most negative speed still counts as moving.
    add_row(0, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 1, BSTAT_INACTIVE, 1000,
                      32'sh8000_0000), '0);
    add_row(0, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 1, BSTAT_INACTIVE, 1000, 0), '0);
    add_row(0, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 1, BSTAT_INACTIVE, 32'sh8000_0000, 0), '0);
    add_row(1, mk_cmd(OP_RELEASE, 0, 0, 1, 1, 1, 1, BSTAT_INACTIVE, 0, 0),
            mk_res(ST_STOPHERE, BRK_NONE, 0, 0, 0, 0, 1));
    // Stop at a negative angle: target clamps to the lower limit, brake held.
    add_row(1, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 1, BSTAT_ACTIVE, -5, 0),
            mk_res(ST_IDLE, BRK_ON, 1, 0, 0, 1, 1));
    add_row(1, mk_cmd(OP_MANUAL, 0, 0, 1, 1, 1, 1, BSTAT_INACTIVE, 0, 0),
            mk_res(ST_MANUAL, BRK_OFF, 0, 0, 0, 0, 1));
    add_row(0, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 1, BSTAT_INACTIVE, 0, 0), '0);
    add_row(0, mk_cmd(OP_RELEASE, 0, 0, 1, 1, 1, 1, BSTAT_INACTIVE, 0, 0), '0);
    // Still moving while stopping at the current angle: keep waiting.
    add_row(0, mk_cmd(OP_UPDATE, 0, 0, 1, 1, 1, 0, BSTAT_INACTIVE, 0, 200000), '0);

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_q[i]) issue_cmd(directed_q[i].c, directed_q[i].typed, directed_q[i].want);

    // Random phases: each picks a limit setting and a handshake pattern, all
    // reprogrammed only once the pipe is empty.
    for (p = 0; p < N_PHASES; p++) begin
      quiesce();
      program_limits(cfg_plan[p % N_SETTINGS]);
      case (p % 4)
        0: begin tx_idle_pct = 0;             rx_stall_pct = 0;             end
        1: begin tx_idle_pct = IDLE_PCT;      rx_stall_pct = 0;             end
        2: begin tx_idle_pct = 0;             rx_stall_pct = IDLE_PCT;      end
        default: begin tx_idle_pct = BOTH_IDLE_PCT; rx_stall_pct = BOTH_IDLE_PCT; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Back-pressure once while commands keep coming; pause the sender once
        // mid-phase until the pipe is dry.
        if (p == 0 && n == ITEMS_PER_PHASE / 2) hold_off_req = 1'b1;
        if (p == 3 && n == ITEMS_PER_PHASE / 2) quiesce();
        issue_cmd(random_cmd(), 1'b0, '0);
      end
    end
    quiesce();

    $display("summary: %0d commands, %0d results checked across %0d limit settings",
             cmds_sent, results_seen, N_SETTINGS);
    $display("summary: states reached %b, %0d move requests, %0d drive disables",
             states_seen, moves_seen, disables_seen);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
